// ===== rtl/sfdc_pkg.sv =====
package sfdc_pkg;

   // Frame layout and counter sizing
   localparam int COUNT_W     = 17;
   localparam int LEN_W       = 16;
   localparam int BYTE_W      = 8;
   localparam int HDR_BYTES   = 6;
   localparam int MIN_FRAME   = 7;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      REG_HEADER_FIRST     = 2'd0,
      REG_HEADER_SECOND    = 2'd1,
      REG_PROTOCOL_VERSION = 2'd2,
      REG_MAX_PAYLOAD      = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_TOO_SHORT    = 3'd1,
      ST_BAD_HEADER   = 3'd2,
      ST_BAD_VERSION  = 3'd3,
      ST_TRUNCATED    = 3'd4,
      ST_CHECKSUM_BAD = 3'd5,
      ST_TOO_LONG     = 3'd6
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header_first;
      logic [BYTE_W-1:0] header_second;
      logic [BYTE_W-1:0] protocol_version;
      logic [LEN_W-1:0]  max_payload;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_in;
      logic              last_in;
   } req_type;

   typedef struct packed {
      logic              is_status;
      logic [BYTE_W-1:0] payload_byte;
      logic [LEN_W-1:0]  payload_index;
      logic [BYTE_W-1:0] command;
      logic [LEN_W-1:0]  payload_length;
      status_type        status;
   } rsp_type;

   // Results produced by one byte: a payload beat, a status beat, or both
   typedef struct packed {
      logic    pay_valid;
      logic    status_valid;
      rsp_type pay;
      rsp_type stat;
   } push_type;

endpackage

// ===== rtl/serial_frame_decoder_checker.sv =====
// Byte-stream frame decoder and checker. Each input beat carries one received
// byte and a flag on the buffer's last byte. A frame is header byte 0, header
// byte 1, version, command, a 16-bit big-endian payload length, the payload,
// and one checksum byte equal to the 8-bit sum of all bytes before it. While
// the header and version match, payload bytes leave as result beats with
// their index; the flagged last byte always closes the buffer with one status
// beat (too short, bad header, bad version, truncated, checksum mismatch,
// payload too long, checked in that order, else ok), after which the decoder
// starts a new frame. Bytes after the checksum byte are ignored. Throughput
// is one byte per clock while the queue has room; a byte is taken into the
// input register, then decoded and written into a four-beat result queue.
// A last byte that is a payload byte of a matching frame yields two result
// beats, payload first; the result port drains one beat per clock unless
// stalled, so the input stalls only while the queue lacks two free slots.
// Registers (APB, byte address 4*i): header_first, header_second,
// protocol_version, max_payload; write them only while idle.
module serial_frame_decoder_checker (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  sfdc_pkg::req_type             req_payload,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sfdc_pkg::rsp_type             rsp_payload,

   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sfdc_pkg::ADDR_W-1:0]   paddr,
   input  logic [sfdc_pkg::DATA_W-1:0]   pwdata,
   output logic [sfdc_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   sfdc_pkg::cfg_type   cfg;
   sfdc_pkg::push_type  push;
   sfdc_pkg::req_type   item_ff;
   logic                in_valid_ff, in_valid_in;
   logic                room;
   logic                advance;
   logic                req_take;

   // Register file for the match values and the payload limit
   sfdc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Input register: advance the held byte into the decoder when the queue
   // can take both possible beats; otherwise hold it and stall the sender.
   assign advance     = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_payload;
      end
   end

   // Per-byte decode, running checksum and frame state
   sfdc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (item_ff),
      .advance (advance),
      .res     (push)
   );

   // Result queue: the output side drains one beat per clock unless stalled
   sfdc_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_en     (advance),
      .push        (push),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/sfdc_csr.sv =====
module sfdc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sfdc_pkg::ADDR_W-1:0]   paddr,
   input  logic [sfdc_pkg::DATA_W-1:0]   pwdata,
   output logic [sfdc_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output sfdc_pkg::cfg_type             cfg
);

   sfdc_pkg::cfg_type       cfg_ff;
   sfdc_pkg::reg_index_type index;
   logic                    wr_en;

   assign index  = sfdc_pkg::reg_index_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first     <= 8'h55;
         cfg_ff.header_second    <= 8'hAA;
         cfg_ff.protocol_version <= 8'h03;
         cfg_ff.max_payload      <= 16'd256;
      end else if (wr_en) begin
         case (index)
            sfdc_pkg::REG_HEADER_FIRST: begin
               cfg_ff.header_first <= pwdata[7:0];
            end
            sfdc_pkg::REG_HEADER_SECOND: begin
               cfg_ff.header_second <= pwdata[7:0];
            end
            sfdc_pkg::REG_PROTOCOL_VERSION: begin
               cfg_ff.protocol_version <= pwdata[7:0];
            end
            sfdc_pkg::REG_MAX_PAYLOAD: begin
               cfg_ff.max_payload <= pwdata[15:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         sfdc_pkg::REG_HEADER_FIRST:     prdata = {24'd0, cfg_ff.header_first};
         sfdc_pkg::REG_HEADER_SECOND:    prdata = {24'd0, cfg_ff.header_second};
         sfdc_pkg::REG_PROTOCOL_VERSION: prdata = {24'd0, cfg_ff.protocol_version};
         sfdc_pkg::REG_MAX_PAYLOAD:      prdata = {16'd0, cfg_ff.max_payload};
         default:                        prdata = '0;
      endcase
   end

endmodule

// ===== rtl/sfdc_core.sv =====
module sfdc_core (
   input  logic                clock,
   input  logic                reset,
   input  sfdc_pkg::cfg_type   cfg,
   input  sfdc_pkg::req_type   item,
   input  logic                advance,
   output sfdc_pkg::push_type  res
);

   localparam logic [sfdc_pkg::COUNT_W-1:0] POS_HDR0    = sfdc_pkg::COUNT_W'(0);
   localparam logic [sfdc_pkg::COUNT_W-1:0] POS_HDR1    = sfdc_pkg::COUNT_W'(1);
   localparam logic [sfdc_pkg::COUNT_W-1:0] POS_VERSION = sfdc_pkg::COUNT_W'(2);
   localparam logic [sfdc_pkg::COUNT_W-1:0] POS_COMMAND = sfdc_pkg::COUNT_W'(3);
   localparam logic [sfdc_pkg::COUNT_W-1:0] POS_LEN_HI  = sfdc_pkg::COUNT_W'(4);
   localparam logic [sfdc_pkg::COUNT_W-1:0] POS_LEN_LO  = sfdc_pkg::COUNT_W'(5);
   localparam logic [sfdc_pkg::COUNT_W-1:0] HDR_LEN     =
      sfdc_pkg::COUNT_W'(sfdc_pkg::HDR_BYTES);
   localparam logic [sfdc_pkg::COUNT_W-1:0] MIN_LEN     =
      sfdc_pkg::COUNT_W'(sfdc_pkg::MIN_FRAME);
   localparam logic [sfdc_pkg::COUNT_W-1:0] COUNT_MAX   = '1;

   logic [sfdc_pkg::COUNT_W-1:0] count_ff,  count_in;
   logic [sfdc_pkg::BYTE_W-1:0]  sum_ff,    sum_in;
   logic [sfdc_pkg::BYTE_W-1:0]  cmd_ff,    cmd_in;
   logic [sfdc_pkg::LEN_W-1:0]   len_ff,    len_in;
   logic                         hdr_ok_ff, hdr_ok_in;
   logic                         ver_ok_ff, ver_ok_in;
   logic                         closed_ff, closed_in;

   logic [sfdc_pkg::COUNT_W-1:0] pos;
   logic [sfdc_pkg::COUNT_W-1:0] end_pos;
   logic [sfdc_pkg::COUNT_W-1:0] pay_pos;
   logic [sfdc_pkg::BYTE_W-1:0]  b;
   sfdc_pkg::status_type         code;

   assign pos     = count_ff;
   assign b       = item.byte_in;
   assign end_pos = HDR_LEN + {1'b0, len_ff};
   assign pay_pos = pos - HDR_LEN;

   always_comb begin
      hdr_ok_in = hdr_ok_ff;
      ver_ok_in = ver_ok_ff;
      cmd_in    = cmd_ff;
      len_in    = len_ff;
      sum_in    = sum_ff;
      closed_in = closed_ff;
      res.pay_valid = 1'b0;

      if (pos == POS_HDR0 && b != cfg.header_first) begin
         hdr_ok_in = 1'b0;
      end
      if (pos == POS_HDR1 && b != cfg.header_second) begin
         hdr_ok_in = 1'b0;
      end
      if (pos == POS_VERSION && b != cfg.protocol_version) begin
         ver_ok_in = 1'b0;
      end
      if (pos == POS_COMMAND) begin
         cmd_in = b;
      end
      if (pos inside {POS_LEN_HI, POS_LEN_LO}) begin
         len_in = {len_ff[7:0], b};
      end

      if (!closed_ff) begin
         if (pos < HDR_LEN) begin
            sum_in = sum_ff + b;
         end else if (pos < end_pos) begin
            sum_in        = sum_ff + b;
            res.pay_valid = hdr_ok_in && ver_ok_in;
         end else if (pos == end_pos) begin
            // fold the checksum in: zero means match
            sum_in    = sum_ff ^ b;
            closed_in = 1'b1;
         end
      end

      count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;

      if (count_in < MIN_LEN) begin
         code = sfdc_pkg::ST_TOO_SHORT;
      end else if (!hdr_ok_in) begin
         code = sfdc_pkg::ST_BAD_HEADER;
      end else if (!ver_ok_in) begin
         code = sfdc_pkg::ST_BAD_VERSION;
      end else if (!closed_in) begin
         code = sfdc_pkg::ST_TRUNCATED;
      end else if (sum_in != '0) begin
         code = sfdc_pkg::ST_CHECKSUM_BAD;
      end else if (len_in > cfg.max_payload) begin
         code = sfdc_pkg::ST_TOO_LONG;
      end else begin
         code = sfdc_pkg::ST_OK;
      end

      res.status_valid         = item.last_in;

      res.pay.is_status        = 1'b0;
      res.pay.payload_byte     = b;
      res.pay.payload_index    = pay_pos[sfdc_pkg::LEN_W-1:0];
      res.pay.command          = cmd_in;
      res.pay.payload_length   = len_in;
      res.pay.status           = sfdc_pkg::ST_OK;

      res.stat.is_status       = 1'b1;
      res.stat.payload_byte    = '0;
      res.stat.payload_index   = '0;
      res.stat.command         = cmd_in;
      res.stat.payload_length  = len_in;
      res.stat.status          = code;
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && item.last_in)) begin
         count_ff  <= '0;
         sum_ff    <= '0;
         cmd_ff    <= '0;
         len_ff    <= '0;
         hdr_ok_ff <= 1'b1;
         ver_ok_ff <= 1'b1;
         closed_ff <= 1'b0;
      end else if (advance) begin
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         cmd_ff    <= cmd_in;
         len_ff    <= len_in;
         hdr_ok_ff <= hdr_ok_in;
         ver_ok_ff <= ver_ok_in;
         closed_ff <= closed_in;
      end
   end

endmodule

// ===== rtl/sfdc_queue.sv =====
module sfdc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_en,
   input  sfdc_pkg::push_type  push,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sfdc_pkg::rsp_type   rsp_payload
);

   sfdc_pkg::rsp_type            entry_ff [sfdc_pkg::QUEUE_DEPTH];
   logic [sfdc_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [sfdc_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [sfdc_pkg::QCNT_W-1:0]  count_ff,  count_in;
   logic [sfdc_pkg::QPTR_W-1:0]  wr_next;
   logic [1:0]                   n_push;
   logic                         pop;
   sfdc_pkg::rsp_type            first;

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;

   // Two free slots after this cycle's pop: one byte yields at most two beats
   assign room = (count_ff <= sfdc_pkg::QCNT_W'(sfdc_pkg::QUEUE_DEPTH - 2)) ||
                 ((count_ff == sfdc_pkg::QCNT_W'(sfdc_pkg::QUEUE_DEPTH - 1)) && pop);

   assign n_push    = push_en ? ({1'b0, push.pay_valid} + {1'b0, push.status_valid}) : 2'd0;
   assign first     = push.pay_valid ? push.pay : push.stat;
   assign wr_next   = wr_ptr_ff + 1'b1;
   assign wr_ptr_in = wr_ptr_ff + sfdc_pkg::QPTR_W'(n_push);
   assign rd_ptr_in = rd_ptr_ff + sfdc_pkg::QPTR_W'(pop);
   assign count_in  = count_ff + sfdc_pkg::QCNT_W'(n_push) - sfdc_pkg::QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         entry_ff[wr_ptr_ff] <= first;
      end
      if (n_push == 2'd2) begin
         entry_ff[wr_next] <= push.stat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== tb/tb_serial_frame_decoder_checker.sv =====
`timescale 1ns / 1ps

module tb_serial_frame_decoder_checker;
   import sfdc_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE_TICKS = 4;     // lets bytes that owe no result beat leave the pipeline
   localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

   // Kinds of damage applied to an otherwise well-formed frame
   typedef enum int {
      FLAW_NONE,
      FLAW_HEADER,
      FLAW_VERSION,
      FLAW_CHECKSUM,
      FLAW_CUT
   } frame_flaw_type;

   // One entry of the outgoing byte stream; hold marks a pause until drained
   typedef struct packed {
      logic    hold;
      req_type beat;
   } byte_entry_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;

   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;

   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   logic                psel    = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite  = 1'b0;
   logic [ADDR_W-1:0]   paddr   = '0;
   logic [DATA_W-1:0]   pwdata  = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   // Stream of bytes still to send and result beats still owed by the block
   byte_entry_type byte_queue[$];
   rsp_type        expected_beats[$];

   // Decoder copy: live register values and per-frame state
   cfg_type           cfg_now = '{header_first: 8'h55, header_second: 8'hAA,
                                  protocol_version: 8'h03, max_payload: 16'd256};
   logic [COUNT_W-1:0] frame_pos    = '0;
   logic [BYTE_W-1:0]  frame_sum    = '0;
   logic [BYTE_W-1:0]  frame_cmd    = '0;
   logic [LEN_W-1:0]   held_len     = '0;
   logic               header_match = 1'b1;
   logic               version_match = 1'b1;
   logic               sum_taken    = 1'b0;

   // Traffic shaping, set per phase
   int  send_idle_pct = 0;
   int  stall_pct     = 0;
   logic waiting_for_drain = 1'b0;
   logic drained_at_fall   = 1'b1;

   int  errors       = 0;
   int  cycle_count  = 0;
   int  bytes_queued = 0;
   int  beats_taken  = 0;
   int  payload_seen = 0;
   int  settings_used = 1;
   int  status_seen[8];

   serial_frame_decoder_checker dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------

   // Drop all per-frame state once a buffer has been closed
   task automatic restart_frame();
      frame_pos     = '0;
      frame_sum     = '0;
      frame_cmd     = '0;
      held_len      = '0;
      header_match  = 1'b1;
      version_match = 1'b1;
      sum_taken     = 1'b0;
   endtask

   // Advance the model by one accepted byte and queue the beats it owes
   task automatic decode_expected(input logic [BYTE_W-1:0] b, input logic last);
      logic [COUNT_W-1:0] end_pos;
      rsp_type            beat;
      status_type         code;
      case (frame_pos)
         0: if (b != cfg_now.header_first) header_match = 1'b0;
         1: if (b != cfg_now.header_second) header_match = 1'b0;
         2: if (b != cfg_now.protocol_version) version_match = 1'b0;
         3: frame_cmd = b;
         4, 5: held_len = {held_len[7:0], b};
         default: ;
      endcase

      // Sum the header and payload; fold the checksum byte in by xor
      if (!sum_taken) begin
         if (frame_pos < COUNT_W'(HDR_BYTES)) begin
            frame_sum += b;
         end else begin
            end_pos = COUNT_W'(HDR_BYTES) + COUNT_W'(held_len);
            if (frame_pos < end_pos) begin
               frame_sum += b;
               if (header_match && version_match) begin
                  beat = '{is_status: 1'b0, payload_byte: b,
                           payload_index: LEN_W'(frame_pos - COUNT_W'(HDR_BYTES)),
                           command: frame_cmd, payload_length: held_len,
                           status: ST_OK};
                  expected_beats.push_back(beat);
               end
            end else if (frame_pos == end_pos) begin
               frame_sum ^= b;
               sum_taken = 1'b1;
            end
         end
      end

      // Saturate rather than wrap on very long buffers
      if (frame_pos != COUNT_TOP) frame_pos++;

      if (last) begin
         if (frame_pos < COUNT_W'(MIN_FRAME))   code = ST_TOO_SHORT;
         else if (!header_match)               code = ST_BAD_HEADER;
         else if (!version_match)              code = ST_BAD_VERSION;
         else if (!sum_taken)                  code = ST_TRUNCATED;
         else if (frame_sum != '0)             code = ST_CHECKSUM_BAD;
         else if (held_len > cfg_now.max_payload) code = ST_TOO_LONG;
         else                                  code = ST_OK;
         beat = '{is_status: 1'b1, payload_byte: '0, payload_index: '0,
                  command: frame_cmd, payload_length: held_len, status: code};
         expected_beats.push_back(beat);
         restart_frame();
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------

   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
      byte_queue.push_back('{hold: 1'b0, beat: '{byte_in: b, last_in: last}});
      bytes_queued++;
   endtask

   // Build one frame against the current settings, damage it as asked,
   // append the checksum and trailing bytes unless cut, and flag the buffer's final byte.
   // keep, when nonzero, cuts a damaged-by-cut frame to that many bytes.
   task automatic queue_frame(input logic [LEN_W-1:0] length, input frame_flaw_type flaw,
                              input int trail, input int keep);
      logic [BYTE_W-1:0] frame[$];
      logic [BYTE_W-1:0] total;
      int                body;
      int                n;
      frame = {cfg_now.header_first, cfg_now.header_second, cfg_now.protocol_version,
               BYTE_W'($urandom), length[15:8], length[7:0]};
      // A cut frame never reaches its checksum, so keep its body short
      body = (flaw == FLAW_CUT && length > 64) ? 64 : int'(length);
      repeat (body) frame.push_back(BYTE_W'($urandom));
      if (flaw == FLAW_HEADER)  frame[$urandom_range(1)] ^= BYTE_W'($urandom_range(255, 1));
      if (flaw == FLAW_VERSION) frame[2] ^= BYTE_W'($urandom_range(255, 1));
      if (flaw == FLAW_CUT) begin
         if (keep != 0)              n = keep;
         else if ($urandom_range(1)) n = $urandom_range(6, 1);
         else                        n = $urandom_range(frame.size(), 1);
      end else begin
         total = '0;
         foreach (frame[i]) total += frame[i];
         if (flaw == FLAW_CHECKSUM) total ^= BYTE_W'($urandom_range(255, 1));
         frame.push_back(total);
         repeat (trail) frame.push_back(BYTE_W'($urandom));
         n = frame.size();
      end
      for (int i = 0; i < n; i++) push_byte(frame[i], i == n - 1);
   endtask

   // Frames with random content, a little over half of them well-formed and the
   // rest damaged, short noise buffers and occasional pauses until the block drains
   task automatic random_traffic(input int target);
      int             start;
      int             pick;
      int             roll;
      frame_flaw_type flaw;
      logic [LEN_W-1:0] length;
      start = bytes_queued;
      while (bytes_queued - start < target) begin
         pick = $urandom_range(99);
         if (pick < 3) begin
            byte_queue.push_back('{hold: 1'b1, beat: '0});
         end else if (pick < 12) begin
            roll = $urandom_range(10, 1);
            for (int i = 0; i < roll; i++) push_byte(BYTE_W'($urandom), i == roll - 1);
         end else begin
            roll = $urandom_range(99);
            flaw = roll < 55 ? FLAW_NONE     :
                   roll < 65 ? FLAW_HEADER   :
                   roll < 73 ? FLAW_VERSION  :
                   roll < 85 ? FLAW_CHECKSUM : FLAW_CUT;
            roll = $urandom_range(99);
            if (flaw == FLAW_CUT && roll < 50) length = LEN_W'($urandom);
            else if (roll < 70)                length = LEN_W'($urandom_range(8));
            else if (roll < 97)                length = LEN_W'($urandom_range(40, 9));
            else                               length = LEN_W'($urandom_range(300, 41));
            queue_frame(length, flaw, ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0, 0);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------

   // Setup cycle, then access cycle; the register lands on the access edge
   task automatic csr_write(input reg_index_type idx, input logic [DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_HEADER_FIRST:     cfg_now.header_first     = value[BYTE_W-1:0];
         REG_HEADER_SECOND:    cfg_now.header_second    = value[BYTE_W-1:0];
         REG_PROTOCOL_VERSION: cfg_now.protocol_version = value[BYTE_W-1:0];
         REG_MAX_PAYLOAD:      cfg_now.max_payload      = value[LEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [BYTE_W-1:0] h0, input logic [BYTE_W-1:0] h1,
                                input logic [BYTE_W-1:0] ver, input logic [LEN_W-1:0] max_len);
      csr_write(REG_HEADER_FIRST, DATA_W'(h0));
      csr_write(REG_HEADER_SECOND, DATA_W'(h1));
      csr_write(REG_PROTOCOL_VERSION, DATA_W'(ver));
      csr_write(REG_MAX_PAYLOAD, DATA_W'(max_len));
      settings_used++;
   endtask

   // Block until every queued byte went in and every owed beat came out,
   // then give bytes that owe nothing time to leave the pipeline
   task automatic wait_idle();
      do @(negedge clock);
      while (byte_queue.size() != 0 || req_valid || waiting_for_drain ||
             expected_beats.size() != 0);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Driver: feed beats from the byte queue, idling at random
   // ------------------------------------------------------------------

   // Sample the drain state at the falling edge so the driver sees a settled value
   always @(negedge clock) drained_at_fall = (expected_beats.size() == 0);

   always @(posedge clock) begin : drive_bytes
      byte_entry_type entry;
      logic           next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // Predict on the edge the beat is taken
         if (req_valid && !req_stall) begin
            decode_expected(req_payload.byte_in, req_payload.last_in);
            beats_taken++;
         end
         // Hold the payload while stalled; otherwise pick the next beat or idle
         if (!req_valid || !req_stall) begin
            next_valid = 1'b0;
            if (waiting_for_drain) begin
               if (drained_at_fall) waiting_for_drain = 1'b0;
            end else if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               entry = byte_queue.pop_front();
               if (entry.hold) begin
                  waiting_for_drain = 1'b1;
               end else begin
                  next_valid = 1'b1;
                  req_payload <= entry.beat;
               end
            end
            req_valid <= next_valid;
         end
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // ------------------------------------------------------------------
   // Monitor: compare each result beat with the oldest expectation
   // ------------------------------------------------------------------

   task automatic compare_field(input string name, input logic [LEN_W-1:0] want,
                                input logic [LEN_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual %p", $time, rsp_payload);
            errors++;
         end else begin
            want = expected_beats.pop_front();
            compare_field("is_status", LEN_W'(want.is_status), LEN_W'(rsp_payload.is_status));
            compare_field("payload_byte", LEN_W'(want.payload_byte),
                          LEN_W'(rsp_payload.payload_byte));
            compare_field("payload_index", want.payload_index, rsp_payload.payload_index);
            compare_field("command", LEN_W'(want.command), LEN_W'(rsp_payload.command));
            compare_field("payload_length", want.payload_length, rsp_payload.payload_length);
            compare_field("status", LEN_W'(want.status), LEN_W'(rsp_payload.status));
            if (rsp_payload.is_status === 1'b1) status_seen[rsp_payload.status]++;
            else payload_seen++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run stopped at cycle limit with %0d beats still owed",
                  $time, expected_beats.size());
         $display("** serial_frame_decoder_checker: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Phases
   // ------------------------------------------------------------------

   initial begin : run_phases
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset settings, no idling: one-byte buffer, empty payload,
      // a pause until everything owed has come back, trailing bytes after
      // the checksum, and a buffer cut on a payload byte so one byte owes
      // both a payload beat and a status beat
      push_byte(8'hFF, 1'b1);
      queue_frame(16'd0, FLAW_NONE, 0, 0);
      byte_queue.push_back('{hold: 1'b1, beat: '0});
      queue_frame(16'd2, FLAW_NONE, 1, 0);
      queue_frame(16'd5, FLAW_CUT, 0, 7);
      wait_idle();

      // Longest length field, cut inside the payload: payload beats carry
      // the full length and the buffer closes as truncated
      queue_frame(16'hFFFF, FLAW_CUT, 0, 40);
      wait_idle();

      // Extreme settings, sender idling: every nonzero length is too long
      apply_setting(8'h00, 8'hFF, 8'h00, 16'h0000);
      send_idle_pct = 54;
      stall_pct     = 0;
      random_traffic(210);
      wait_idle();

      // Opposite extremes, receiver stalling
      apply_setting(8'hFF, 8'h00, 8'hFF, 16'hFFFF);
      send_idle_pct = 0;
      stall_pct     = 54;
      random_traffic(210);
      wait_idle();

      // Random headers, small payload limit, light idling on both sides
      apply_setting(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                    LEN_W'($urandom_range(40)));
      send_idle_pct = 13;
      stall_pct     = 13;
      random_traffic(210);
      wait_idle();

      // Back to reset values at full rate
      apply_setting(8'h55, 8'hAA, 8'h03, 16'd256);
      send_idle_pct = 0;
      stall_pct     = 0;
      random_traffic(210);
      wait_idle();

      if (expected_beats.size() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time, expected_beats.size());
         errors++;
      end

      $display("Run sent %0d bytes under %0d register settings; %0d payload beats checked",
               beats_taken, settings_used, payload_seen);
      $display("Frame outcomes ok/short/header/version/truncated/checksum/too-long: "
               , "%0d/%0d/%0d/%0d/%0d/%0d/%0d", status_seen[0], status_seen[1],
               status_seen[2], status_seen[3], status_seen[4], status_seen[5], status_seen[6]);
      if (errors == 0) begin
         $display("** serial_frame_decoder_checker: PASSED **");
      end else begin
         $display("** serial_frame_decoder_checker: FAILED **");
      end
      $finish;
   end

endmodule

// ===== serial_frame_decoder_checker.f =====
rtl/sfdc_pkg.sv
rtl/sfdc_csr.sv
rtl/sfdc_core.sv
rtl/sfdc_queue.sv
rtl/serial_frame_decoder_checker.sv
tb/tb_serial_frame_decoder_checker.sv
